[sv/meter_map_time_converter_defines.svh]
// assertion macros for the meter map time converter
`ifndef METER_MAP_TIME_CONVERTER_DEFINES_SVH
`define METER_MAP_TIME_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS

`define MMTC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mmtc check failed");

`define MMTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mmtc check failed");

`else

`define MMTC_ASSERT_SAME(label, clk, rst, ante, cons)

`define MMTC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/mmtc_pkg.sv]
`timescale 1ns / 1ps

package mmtc_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam logic [31:0] WHOLE_TICKS = 32'd768;
   localparam logic [31:0] QUARTER_TICKS = WHOLE_TICKS / 4;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TIME = 2'd1;
   localparam logic [1:0] OP_POS  = 2'd2;

   typedef struct packed {
      logic [31:0] start;
      logic [15:0] bar;
      logic [7:0]  beats;
      logic [7:0]  den;
      logic [7:0]  sub;
   } entry_type;

   localparam entry_type DEFAULT_METER = '{start: 32'd0, bar: 16'd1, beats: 8'd4,
                                           den: 8'd4, sub: 8'd4};

endpackage

[sv/meter_map_time_converter.sv]
// Meter map time converter. A load item (opcode 0) writes one time-signature entry into the
// table, and its all-zero result passes through the done state into the output register. A
// time-to-position item (opcode 1) and a position-to-time item (opcode 2) first scan the
// table one entry at a time, each through a read state and a compare state (one memory read
// port, registered data), stopping at the first later entry that lies past the query or at
// the number of entries in use. They then run on one shared 32x32 multiplier and one shared
// radix-2 divider. When no entry applies, plain 4/4 is used, and opcode 2 then skips the
// divider. The input is stalled while an item is at work; a finished result waits in the
// output register and the next item may be taken meanwhile. The user must see that
// entries_in_use is written only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

`include "meter_map_time_converter_defines.svh"

module meter_map_time_converter
   import mmtc_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_entry_index,
   input  logic [31:0] req_entry_start_time,
   input  logic [15:0] req_entry_start_bar,
   input  logic [7:0]  req_entry_beats,
   input  logic [7:0]  req_entry_denominator,
   input  logic [7:0]  req_entry_subdivisions,
   input  logic [31:0] req_query_time,
   input  logic [15:0] req_query_bar,
   input  logic [7:0]  req_query_beat,
   input  logic [7:0]  req_query_tick,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_bar_number,
   output logic [15:0] rsp_beat_number,
   output logic [31:0] rsp_tick_in_beat,
   output logic [31:0] rsp_ticks_per_beat,
   output logic [31:0] rsp_next_beat_time,
   output logic [7:0]  rsp_subdivisions,
   output logic [7:0]  rsp_beats_in_bar,
   output logic [31:0] rsp_time_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_entries_in_use
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [20:0] {
      S_IDLE   = 21'h000001,
      S_READ   = 21'h000002,
      S_COMP   = 21'h000004,
      S_DIV    = 21'h000008,
      S_T_PB   = 21'h000010,
      S_T_PBAR = 21'h000020,
      S_T_Q1   = 21'h000040,
      S_T_Q2   = 21'h000080,
      S_T_BEAT = 21'h000100,
      S_T_LATE = 21'h000200,
      S_T_FIN  = 21'h000400,
      S_B_REL  = 21'h000800,
      S_B_X    = 21'h001000,
      S_B_D    = 21'h002000,
      S_B_T    = 21'h004000,
      S_B_D2   = 21'h008000,
      S_B_FIN  = 21'h010000,
      S_B_DEF  = 21'h020000,
      S_B_DEF2 = 21'h040000,
      S_B_DEF3 = 21'h080000,
      S_DONE   = 21'h100000
   } state_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_ff;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [4:0]    cfg_ff;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   tm_ff, tm_in;
   logic [15:0]   qbar_ff, qbar_in;
   logic [7:0]    qbeat_ff, qbeat_in;
   logic [7:0]    qtick_ff, qtick_in;
   logic [CW-1:0] live_ff, live_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;
   entry_type     m_ff, m_in;
   logic [31:0]   per_beat_ff, per_beat_in;
   logic [31:0]   per_bar_ff, per_bar_in;
   logic [15:0]   bar_ff, bar_in;
   logic [15:0]   beat_ff, beat_in;
   logic [31:0]   tick_ff, tick_in;
   logic [31:0]   t1_ff, t1_in;
   logic [31:0]   t2_ff, t2_in;
   logic [31:0]   later_ff, later_in;
   logic [31:0]   time_ff, time_in;

   logic [31:0]   div_rem_ff, div_rem_in;
   logic [31:0]   div_quo_ff, div_quo_in;
   logic [31:0]   div_den_ff, div_den_in;
   logic          div_zero_ff, div_zero_in;
   logic [5:0]    div_cnt_ff, div_cnt_in;
   logic [31:0]   div_q, div_r;
   logic [33:0]   div_diff;

   logic [31:0]   mul_a, mul_b, mul_p;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   o_bar_ff, o_beat_ff;
   logic [31:0]   o_tick_ff, o_pb_ff, o_next_ff, o_time_ff;
   logic [7:0]    o_sub_ff, o_beats_ff;
   logic          load_out;

   logic          accept, key_le, more, found_now;
   logic [31:0]   n_req;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign div_q    = div_zero_ff ? 32'd0 : div_quo_ff;
   assign div_r    = div_rem_ff;
   assign div_diff = {1'b0, div_rem_ff, div_quo_ff[31]} - {2'b00, div_den_ff};
   assign mul_p    = mul_a * mul_b;

   assign n_req = 32'(cfg_ff);
   assign key_le = (op_ff == OP_TIME) ? (rd_ff.start <= tm_ff) : (rd_ff.bar <= qbar_ff);
   assign more = (idx_ff == '0 || key_le) &&
                 ((CW'(idx_ff) + CW'(1)) < live_ff);
   assign found_now = key_le || ((idx_ff != '0) && found_ff);

   // shared multiplier operand selection
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      unique case (state_ff)
         S_T_PBAR: begin
            mul_a = div_q;
            mul_b = {24'd0, m_ff.beats};
         end
         S_T_BEAT: begin
            mul_a = {16'd0, bar_ff} - {16'd0, m_ff.bar};
            mul_b = per_bar_ff;
         end
         S_T_LATE: begin
            mul_a = per_beat_ff;
            mul_b = {16'd0, beat_ff};
         end
         S_B_REL: begin
            mul_a = {16'd0, qbar_ff - m_ff.bar};
            mul_b = WHOLE_TICKS;
         end
         S_B_X: begin
            mul_a = t1_ff;
            mul_b = {24'd0, m_ff.beats};
         end
         S_B_T, S_B_DEF2: begin
            mul_a = {24'd0, qbeat_ff} - 32'd1;
            mul_b = WHOLE_TICKS;
         end
         S_B_DEF: begin
            mul_a = {16'd0, qbar_ff} - 32'd1;
            mul_b = WHOLE_TICKS;
         end
         S_IDLE, S_READ, S_COMP, S_DIV, S_T_PB, S_T_Q1, S_T_Q2, S_T_FIN,
         S_B_D, S_B_D2, S_B_FIN, S_B_DEF3, S_DONE: begin
            mul_a = 32'd0;
         end
         default: begin
            mul_a = 32'd0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      op_in       = op_ff;
      tm_in       = tm_ff;
      qbar_in     = qbar_ff;
      qbeat_in    = qbeat_ff;
      qtick_in    = qtick_ff;
      live_in     = live_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      m_in        = m_ff;
      per_beat_in = per_beat_ff;
      per_bar_in  = per_bar_ff;
      bar_in      = bar_ff;
      beat_in     = beat_ff;
      tick_in     = tick_ff;
      t1_in       = t1_ff;
      t2_in       = t2_ff;
      later_in    = later_ff;
      time_in     = time_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_den_in  = div_den_ff;
      div_zero_in = div_zero_ff;
      div_cnt_in  = div_cnt_ff;
      load_out    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               tm_in    = req_query_time;
               qbar_in  = req_query_bar;
               qbeat_in = req_query_beat;
               qtick_in = req_query_tick;
               idx_in   = '0;
               found_in = 1'b0;
               live_in  = (n_req > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cfg_ff);
               m_in     = DEFAULT_METER;
               if (req_opcode == OP_TIME || req_opcode == OP_POS) begin
                  if (((n_req > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : n_req) != 32'd0) begin
                     state_in = S_READ;
                  end else if (req_opcode == OP_TIME) begin
                     state_in = S_T_PB;
                  end else begin
                     state_in = S_B_DEF;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            state_in = S_COMP;
         end
         S_COMP: begin
            if (idx_ff == '0 || key_le) begin
               m_in = rd_ff;
            end
            found_in = found_now;
            if (more) begin
               idx_in   = AW'(CW'(idx_ff) + CW'(1));
               state_in = S_READ;
            end else begin
               if (!found_now) begin
                  m_in = DEFAULT_METER;
               end
               if (op_ff == OP_TIME) begin
                  state_in = S_T_PB;
               end else if (found_now) begin
                  state_in = S_B_REL;
               end else begin
                  state_in = S_B_DEF;
               end
            end
         end
         S_DIV: begin
            // one quotient bit per cycle, restoring
            if (!div_diff[33]) begin
               div_rem_in = div_diff[31:0];
               div_quo_in = {div_quo_ff[30:0], 1'b1};
            end else begin
               div_rem_in = {div_rem_ff[30:0], div_quo_ff[31]};
               div_quo_in = {div_quo_ff[30:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == 6'd1) begin
               state_in = ret_ff;
            end
         end
         S_T_PB: begin
            div_rem_in  = 32'd0;
            div_quo_in  = WHOLE_TICKS;
            div_den_in  = {24'd0, m_ff.den};
            div_zero_in = (m_ff.den == 8'd0);
            div_cnt_in  = 6'd32;
            ret_in      = S_T_PBAR;
            state_in    = S_DIV;
         end
         S_T_PBAR: begin
            per_beat_in = div_q;
            per_bar_in  = mul_p;
            state_in    = S_T_Q1;
         end
         S_T_Q1: begin
            div_rem_in  = 32'd0;
            div_quo_in  = tm_ff - m_ff.start;
            div_den_in  = per_bar_ff;
            div_zero_in = (per_bar_ff == 32'd0);
            div_cnt_in  = 6'd32;
            ret_in      = S_T_Q2;
            state_in    = S_DIV;
         end
         S_T_Q2: begin
            bar_in      = m_ff.bar + div_q[15:0];
            div_rem_in  = 32'd0;
            div_quo_in  = div_r;
            div_den_in  = per_beat_ff;
            div_zero_in = (per_beat_ff == 32'd0);
            div_cnt_in  = 6'd32;
            ret_in      = S_T_BEAT;
            state_in    = S_DIV;
         end
         S_T_BEAT: begin
            beat_in  = div_q[15:0] + 16'd1;
            tick_in  = div_r;
            t1_in    = mul_p;
            state_in = S_T_LATE;
         end
         S_T_LATE: begin
            t2_in    = mul_p;
            state_in = S_T_FIN;
         end
         S_T_FIN: begin
            later_in = m_ff.start + t1_ff + t2_ff;
            state_in = S_DONE;
         end
         S_B_REL: begin
            t1_in    = mul_p;
            state_in = S_B_X;
         end
         S_B_X: begin
            t1_in    = mul_p;
            state_in = S_B_D;
         end
         S_B_D: begin
            div_rem_in  = 32'd0;
            div_quo_in  = t1_ff;
            div_den_in  = {24'd0, m_ff.den};
            div_zero_in = (m_ff.den == 8'd0);
            div_cnt_in  = 6'd32;
            ret_in      = S_B_T;
            state_in    = S_DIV;
         end
         S_B_T: begin
            t2_in = m_ff.start + div_q;
            t1_in = mul_p;
            // beat zero steps back one beat instead
            div_rem_in  = 32'd0;
            div_quo_in  = (qbeat_ff == 8'd0) ? WHOLE_TICKS : mul_p;
            div_den_in  = {24'd0, m_ff.den};
            div_zero_in = (m_ff.den == 8'd0);
            div_cnt_in  = 6'd32;
            ret_in      = S_B_FIN;
            state_in    = S_B_D2;
         end
         S_B_D2: begin
            state_in = S_DIV;
         end
         S_B_FIN: begin
            time_in  = ((qbeat_ff == 8'd0) ? (t2_ff - div_q) : (t2_ff + div_q)) +
                       {24'd0, qtick_ff};
            state_in = S_DONE;
         end
         S_B_DEF: begin
            t2_in    = mul_p;
            state_in = S_B_DEF2;
         end
         S_B_DEF2: begin
            t1_in    = mul_p;
            state_in = S_B_DEF3;
         end
         S_B_DEF3: begin
            time_in  = ((qbeat_ff == 8'd0) ? (t2_ff - QUARTER_TICKS) :
                        (t2_ff + {2'b00, t1_ff[31:2]})) + {24'd0, qtick_ff};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         cfg_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= 6'd0;
         live_ff      <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         op_ff        <= OP_LOAD;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
         live_ff      <= live_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         op_ff        <= op_in;
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_entries_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      tm_ff       <= tm_in;
      qbar_ff     <= qbar_in;
      qbeat_ff    <= qbeat_in;
      qtick_ff    <= qtick_in;
      m_ff        <= m_in;
      per_beat_ff <= per_beat_in;
      per_bar_ff  <= per_bar_in;
      bar_ff      <= bar_in;
      beat_ff     <= beat_in;
      tick_ff     <= tick_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      later_ff    <= later_in;
      time_ff     <= time_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_den_ff  <= div_den_in;
      div_zero_ff <= div_zero_in;
      if (load_out) begin
         o_bar_ff   <= (op_ff == OP_TIME) ? bar_ff : 16'd0;
         o_beat_ff  <= (op_ff == OP_TIME) ? beat_ff : 16'd0;
         o_tick_ff  <= (op_ff == OP_TIME) ? tick_ff : 32'd0;
         o_pb_ff    <= (op_ff == OP_TIME) ? per_beat_ff : 32'd0;
         o_next_ff  <= (op_ff == OP_TIME) ? later_ff : 32'd0;
         o_sub_ff   <= (op_ff == OP_TIME) ? m_ff.sub : 8'd0;
         o_beats_ff <= (op_ff == OP_TIME) ? m_ff.beats : 8'd0;
         o_time_ff  <= (op_ff == OP_POS) ? time_ff : 32'd0;
      end
   end

   // signature table
   always_ff @(posedge clock) begin
      if (accept && req_opcode == OP_LOAD && 32'(req_entry_index) < 32'(TABLE_DEPTH)) begin
         mem[AW'(req_entry_index)] <= '{start: req_entry_start_time,
                                        bar: req_entry_start_bar,
                                        beats: req_entry_beats,
                                        den: req_entry_denominator,
                                        sub: req_entry_subdivisions};
      end
      if (state_ff == S_READ) begin
         rd_ff <= mem[idx_ff];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bar_number     = o_bar_ff;
   assign rsp_beat_number    = o_beat_ff;
   assign rsp_tick_in_beat   = o_tick_ff;
   assign rsp_ticks_per_beat = o_pb_ff;
   assign rsp_next_beat_time = o_next_ff;
   assign rsp_subdivisions   = o_sub_ff;
   assign rsp_beats_in_bar   = o_beats_ff;
   assign rsp_time_result    = o_time_ff;

   `MMTC_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != S_IDLE)
   `MMTC_ASSERT_SAME(a_div_count_live, clock, reset, state_ff == S_DIV, div_cnt_ff != 6'd0)
   `MMTC_ASSERT_SAME(a_scan_in_range, clock, reset, state_ff == S_COMP, CW'(idx_ff) < live_ff)

endmodule

[tb/meter_map_time_converter_tb.sv]
`timescale 1ns / 1ps

module meter_map_time_converter_tb
   import mmtc_pkg::*;
();

   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct {
      logic [1:0]  opcode;
      logic [3:0]  entry_index;
      logic [31:0] entry_start_time;
      logic [15:0] entry_start_bar;
      logic [7:0]  entry_beats;
      logic [7:0]  entry_denominator;
      logic [7:0]  entry_subdivisions;
      logic [31:0] query_time;
      logic [15:0] query_bar;
      logic [7:0]  query_beat;
      logic [7:0]  query_tick;
   } meter_req_type;

   typedef struct {
      logic [15:0] bar_number;
      logic [15:0] beat_number;
      logic [31:0] tick_in_beat;
      logic [31:0] ticks_per_beat;
      logic [31:0] next_beat_time;
      logic [7:0]  subdivisions;
      logic [7:0]  beats_in_bar;
      logic [31:0] time_result;
   } meter_rsp_type;

   class scoreboard_type;
      entry_type     sig_table[16];
      logic [4:0]    entries_in_use;
      meter_rsp_type expected_q[$];
      int            errors;
      int            results_seen;

      function new();
         entries_in_use = '0;
         errors = 0;
         results_seen = 0;
         foreach (sig_table[i]) sig_table[i] = '0;
      endfunction

      function logic [31:0] qdiv(logic [31:0] a, logic [31:0] b);
         return (b != 0) ? a / b : 32'd0;
      endfunction

      function logic [31:0] qrem(logic [31:0] a, logic [31:0] b);
         return (b != 0) ? a % b : a;
      endfunction

      function int live_count();
         return (entries_in_use > 16) ? 16 : int'(entries_in_use);
      endfunction

      function meter_rsp_type time_to_position(logic [31:0] tm);
         meter_rsp_type r;
         entry_type m;
         int n;
         int p;
         logic [31:0] per_beat, per_bar, off, in_bar, bar32, beat32;
         r = '{default: '0};
         n = live_count();
         p = 0;
         while (p + 1 < n && sig_table[p + 1].start <= tm) p++;
         if (p < n && sig_table[p].start <= tm) m = sig_table[p];
         else m = DEFAULT_METER;
         per_beat = qdiv(WHOLE_TICKS, {24'd0, m.den});
         per_bar = per_beat * {24'd0, m.beats};
         off = tm - m.start;
         in_bar = qrem(off, per_bar);
         bar32 = ({16'd0, m.bar} + qdiv(off, per_bar)) & 32'hFFFF;
         beat32 = (32'd1 + qdiv(in_bar, per_beat)) & 32'hFFFF;
         r.bar_number = bar32[15:0];
         r.beat_number = beat32[15:0];
         r.tick_in_beat = qrem(in_bar, per_beat);
         r.ticks_per_beat = per_beat;
         r.next_beat_time = m.start + (bar32 - {16'd0, m.bar}) * per_bar + per_beat * beat32;
         r.subdivisions = m.sub;
         r.beats_in_bar = m.beats;
         return r;
      endfunction

      function logic [31:0] position_to_time(logic [15:0] b, logic [7:0] beat);
         int n;
         int s;
         entry_type m;
         logic [31:0] t, rel, b32, beat32;
         n = live_count();
         s = 0;
         b32 = {16'd0, b};
         beat32 = {24'd0, beat};
         while (s + 1 < n && sig_table[s + 1].bar <= b) s++;
         if (s >= n || sig_table[s].bar > b) begin
            // plain 4/4 counted from bar 1
            t = (b32 - 32'd1) * WHOLE_TICKS;
            if (beat == 0) return t - QUARTER_TICKS;
            return t + (beat32 - 32'd1) * WHOLE_TICKS / 32'd4;
         end
         m = sig_table[s];
         rel = (b32 - {16'd0, m.bar}) & 32'hFFFF;
         t = m.start + qdiv(rel * WHOLE_TICKS * {24'd0, m.beats}, {24'd0, m.den});
         if (beat == 0) return t - qdiv(WHOLE_TICKS, {24'd0, m.den});
         return t + qdiv((beat32 - 32'd1) * WHOLE_TICKS, {24'd0, m.den});
      endfunction

      function void set_count(logic [4:0] v);
         entries_in_use = v;
      endfunction

      function void note_item(meter_req_type q);
         meter_rsp_type r;
         r = '{default: '0};
         case (q.opcode)
            OP_LOAD: begin
               sig_table[q.entry_index] = '{start: q.entry_start_time,
                                            bar: q.entry_start_bar,
                                            beats: q.entry_beats, den: q.entry_denominator,
                                            sub: q.entry_subdivisions};
            end
            OP_TIME: r = time_to_position(q.query_time);
            OP_POS: r.time_result = position_to_time(q.query_bar, q.query_beat)
                                    + {24'd0, q.query_tick};
            default: ;
         endcase
         expected_q.push_back(r);
      endfunction

      function void cmp(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            errors++;
            $display("%0t mismatch %s expected %0h actual %0h", $time, name, e, a);
         end
      endfunction

      function void check_result(meter_rsp_type a);
         meter_rsp_type e;
         results_seen++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result item, expected none, actual time %0h",
                     $time, a.time_result);
            return;
         end
         e = expected_q.pop_front();
         cmp("bar_number", 32'(e.bar_number), 32'(a.bar_number));
         cmp("beat_number", 32'(e.beat_number), 32'(a.beat_number));
         cmp("tick_in_beat", e.tick_in_beat, a.tick_in_beat);
         cmp("ticks_per_beat", e.ticks_per_beat, a.ticks_per_beat);
         cmp("next_beat_time", e.next_beat_time, a.next_beat_time);
         cmp("subdivisions", 32'(e.subdivisions), 32'(a.subdivisions));
         cmp("beats_in_bar", 32'(e.beats_in_bar), 32'(a.beats_in_bar));
         cmp("time_result", e.time_result, a.time_result);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [3:0]  req_entry_index = '0;
   logic [31:0] req_entry_start_time = '0;
   logic [15:0] req_entry_start_bar = '0;
   logic [7:0]  req_entry_beats = '0;
   logic [7:0]  req_entry_denominator = '0;
   logic [7:0]  req_entry_subdivisions = '0;
   logic [31:0] req_query_time = '0;
   logic [15:0] req_query_bar = '0;
   logic [7:0]  req_query_beat = '0;
   logic [7:0]  req_query_tick = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_bar_number;
   logic [15:0] rsp_beat_number;
   logic [31:0] rsp_tick_in_beat;
   logic [31:0] rsp_ticks_per_beat;
   logic [31:0] rsp_next_beat_time;
   logic [7:0]  rsp_subdivisions;
   logic [7:0]  rsp_beats_in_bar;
   logic [31:0] rsp_time_result;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_entries_in_use = '0;

   scoreboard_type sb = new();
   int          items_sent = 0;
   bit          quiet = 1'b0;
   logic [15:0] written = '0;
   entry_type   loaded[16];
   int          drain_cycles = 200;

   meter_map_time_converter i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_entry_index(req_entry_index), .req_entry_start_time(req_entry_start_time),
      .req_entry_start_bar(req_entry_start_bar), .req_entry_beats(req_entry_beats),
      .req_entry_denominator(req_entry_denominator),
      .req_entry_subdivisions(req_entry_subdivisions), .req_query_time(req_query_time),
      .req_query_bar(req_query_bar), .req_query_beat(req_query_beat),
      .req_query_tick(req_query_tick),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_bar_number(rsp_bar_number),
      .rsp_beat_number(rsp_beat_number), .rsp_tick_in_beat(rsp_tick_in_beat),
      .rsp_ticks_per_beat(rsp_ticks_per_beat), .rsp_next_beat_time(rsp_next_beat_time),
      .rsp_subdivisions(rsp_subdivisions), .rsp_beats_in_bar(rsp_beats_in_bar),
      .rsp_time_result(rsp_time_result),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_entries_in_use(csr_entries_in_use)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 37);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result('{rsp_bar_number, rsp_beat_number, rsp_tick_in_beat,
                           rsp_ticks_per_beat, rsp_next_beat_time, rsp_subdivisions,
                           rsp_beats_in_bar, rsp_time_result});
      end
   end

   task automatic send(meter_req_type q);
      if (!quiet && $urandom_range(99) < 37) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_opcode = q.opcode;
      req_entry_index = q.entry_index;
      req_entry_start_time = q.entry_start_time;
      req_entry_start_bar = q.entry_start_bar;
      req_entry_beats = q.entry_beats;
      req_entry_denominator = q.entry_denominator;
      req_entry_subdivisions = q.entry_subdivisions;
      req_query_time = q.query_time;
      req_query_bar = q.query_bar;
      req_query_beat = q.query_beat;
      req_query_tick = q.query_tick;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(q);
      if (q.opcode == OP_LOAD) begin
         written[q.entry_index] = 1'b1;
         loaded[q.entry_index] = '{start: q.entry_start_time, bar: q.entry_start_bar,
                                   beats: q.entry_beats, den: q.entry_denominator,
                                   sub: q.entry_subdivisions};
      end
      items_sent++;
      quiet = (items_sent >= 700 && items_sent < 900);
      @(negedge clock);
   endtask

   task automatic load_entry(int slot, logic [31:0] st, logic [15:0] br,
                             logic [7:0] bt, logic [7:0] dn, logic [7:0] sd);
      meter_req_type q;
      q = '{default: '0};
      q.opcode = OP_LOAD;
      q.entry_index = slot[3:0];
      q.entry_start_time = st;
      q.entry_start_bar = br;
      q.entry_beats = bt;
      q.entry_denominator = dn;
      q.entry_subdivisions = sd;
      q.query_time = $urandom();
      q.query_bar = 16'($urandom());
      send(q);
   endtask

   task automatic query(logic [1:0] op, logic [31:0] tm, logic [15:0] br,
                        logic [7:0] bt, logic [7:0] tk);
      meter_req_type q;
      q = '{default: '0};
      q.opcode = op;
      q.entry_index = 4'($urandom());
      q.entry_start_time = $urandom();
      q.entry_start_bar = 16'($urandom());
      q.entry_beats = 8'($urandom());
      q.query_time = tm;
      q.query_bar = br;
      q.query_beat = bt;
      q.query_tick = tk;
      send(q);
   endtask

   // register write only with nothing in flight
   task automatic write_count(logic [4:0] v);
      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (drain_cycles) @(negedge clock);
      csr_entries_in_use = v;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_count(v);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [7:0] pick_den();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2, 3, 4: return 8'd1 << $urandom_range(0, 5);
         5: return 8'd3;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_beats();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2, 3, 4: return 8'($urandom_range(2, 7));
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic random_query(int n);
      int s;
      logic [31:0] tm;
      logic [15:0] br;
      s = (n > 0) ? int'($urandom_range(n - 1)) : 0;
      case ($urandom_range(19))
         0: load_entry(s, loaded[s].start + $urandom_range(0, 99), loaded[s].bar,
                       pick_beats(), pick_den(), 8'($urandom()));
         1: query(OP_NONE, $urandom(), 16'($urandom()), 8'($urandom()), 8'($urandom()));
         2, 3, 4, 5, 6, 7, 8, 9, 10: begin
            case ($urandom_range(3))
               0: tm = $urandom();
               1: tm = loaded[s].start - $urandom_range(0, 3);
               default: tm = loaded[s].start + $urandom_range(0, 20000);
            endcase
            if (n == 0 && $urandom_range(1)) tm = $urandom_range(0, 20000);
            query(OP_TIME, tm, 16'($urandom()), 8'($urandom()), 8'($urandom()));
         end
         default: begin
            case ($urandom_range(3))
               0: br = 16'($urandom());
               1: br = 16'(loaded[s].bar - $urandom_range(0, 2));
               default: br = 16'(loaded[s].bar + $urandom_range(0, 40));
            endcase
            query(OP_POS, $urandom(), br,
                  $urandom_range(0, 12) == 0 ? 8'd0 : 8'($urandom()), 8'($urandom()));
         end
      endcase
   endtask

   initial begin
      logic [31:0] st;
      logic [15:0] br;
      int target;
      int n;
      foreach (loaded[i]) loaded[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default 4/4 with empty table, extremes of the query fields
      query(OP_TIME, 32'd0, 16'd0, 8'd0, 8'd0);
      query(OP_TIME, 32'hFFFF_FFFF, 16'd0, 8'd0, 8'd0);
      query(OP_POS, 32'd0, 16'd0, 8'd1, 8'd0);
      query(OP_POS, 32'd0, 16'd0, 8'd0, 8'd255);
      query(OP_POS, 32'd0, 16'hFFFF, 8'd255, 8'd255);
      query(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF);
      load_entry(0, 32'd0, 16'd1, 8'd3, 8'd4, 8'd2);
      load_entry(1, 32'd1000, 16'd5, 8'd0, 8'd8, 8'd1);
      load_entry(2, 32'd5000, 16'd9, 8'd7, 8'd0, 8'd255);
      load_entry(3, 32'hFFFF_FF00, 16'hFFFF, 8'd255, 8'd255, 8'd3);
      write_count(5'd4);
      query(OP_TIME, 32'd999, 16'd0, 8'd0, 8'd0);
      query(OP_TIME, 32'd1200, 16'd0, 8'd0, 8'd0);
      query(OP_TIME, 32'd6000, 16'd0, 8'd0, 8'd0);
      query(OP_TIME, 32'hFFFF_FFFF, 16'd0, 8'd0, 8'd0);
      query(OP_POS, 32'd0, 16'd0, 8'd1, 8'd0);
      query(OP_POS, 32'd0, 16'd6, 8'd0, 8'd7);
      query(OP_POS, 32'd0, 16'd12, 8'd2, 8'd0);
      query(OP_POS, 32'd0, 16'hFFFF, 8'd255, 8'd255);
      // a late entry starting at bar 0 hides the default below the first start
      load_entry(0, 32'd100, 16'd0, 8'd4, 8'd1, 8'd4);
      query(OP_TIME, 32'd50, 16'd0, 8'd0, 8'd0);
      query(OP_POS, 32'd0, 16'd0, 8'd0, 8'd0);

      while (items_sent < 1850) begin
         case ($urandom_range(5))
            0: target = 0;
            1: target = 16;
            2: target = (written == 16'hFFFF) ? int'($urandom_range(17, 31)) : 16;
            default: target = int'($urandom_range(1, 6));
         endcase
         n = (target > 16) ? 16 : target;
         st = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 3000);
         br = $urandom_range(0, 4) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 8));
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
               // out-of-order content
               load_entry(i, $urandom(), 16'($urandom()), pick_beats(), pick_den(),
                          8'($urandom()));
            end else begin
               load_entry(i, st, br, pick_beats(), pick_den(), 8'($urandom_range(1, 255)));
               st = st + $urandom_range(0, 6000);
               br = 16'(br + $urandom_range(0, 12));
            end
         end
         write_count(target[4:0]);
         repeat ($urandom_range(40, 90)) random_query(n);
      end

      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (drain_cycles) @(posedge clock);
      $display("covered %0d items and %0d results over table sizes 0 to 16 and counts to 31",
               items_sent, sb.results_seen);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("timeout with %0d results still expected", sb.expected_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
